FILE: rtl/core/ghcs_pkg.sv
// shared types and constants for the gripper homing calibration sequencer
`default_nettype none
package ghcs_pkg;

    typedef struct packed {
        logic               action;
        logic signed [31:0] joint_position;
        logic signed [31:0] joint_velocity;
        logic [39:0]        odometer;
        logic signed [31:0] actuator_position;
    } ghcs_in_t;

    typedef struct packed {
        logic               command_valid;
        logic signed [31:0] command_position;
        logic               drive_enable;
        logic               zero_write;
        logic signed [31:0] actuator_zero;
        logic               calibrated;
        logic [1:0]         fault;
        logic [2:0]         phase;
    } ghcs_out_t;

    // phase codes
    localparam logic [2:0] PH_INIT    = 3'd0;
    localparam logic [2:0] PH_START   = 3'd1;
    localparam logic [2:0] PH_CLOSE   = 3'd2;
    localparam logic [2:0] PH_BACKOFF = 3'd3;
    localparam logic [2:0] PH_TOP     = 3'd4;
    localparam logic [2:0] PH_HOME    = 3'd5;
    localparam logic [2:0] PH_CAL     = 3'd6;
    // unused code, behaves as calibrated
    localparam logic [2:0] PH_SPARE   = 3'd7;

    // fault codes
    localparam logic [1:0] FLT_NONE      = 2'd0;
    localparam logic [1:0] FLT_NOT_MOVED = 2'd1;
    localparam logic [1:0] FLT_WRONG     = 2'd2;
    localparam logic [1:0] FLT_MISSING   = 2'd3;

    // configuration register indexes
    localparam logic CFG_STOP_VEL = 1'b0;
    localparam logic CFG_SETTLE   = 1'b1;

    // goal positions in nm
    localparam logic signed [31:0] G_MT_TOP     = 32'sd16500000;
    localparam logic signed [31:0] G_EMPTY      = 32'sd15000000;
    localparam logic signed [31:0] G_OPEN       = 32'sd11300000;
    localparam logic signed [31:0] G_BO_INSTALL = 32'sd700000;
    localparam logic signed [31:0] G_WRONG      = 32'sd9000000;
    localparam logic signed [31:0] G_BO_BOTTOM  = 32'sd3000000;
    localparam logic signed [31:0] G_MT_CLOSED  = -32'sd4000000;
    localparam logic signed [31:0] G_MT_BOTTOM  = -32'sd17000000;

    localparam logic [40:0] ODO_MIN_MOVE = 41'd1000000;
    localparam logic [1:0]  CLOSE_PASSES = 2'd2;

    localparam logic [30:0] STOP_VEL_RESET = 31'd1000000;
    localparam logic [15:0] SETTLE_RESET   = 16'd600;

    // clamp a wide signed sum into the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gripper_homing_calibration_sequencer.sv
// top level of the gripper homing calibration sequencer
//
// usage:
//   s_ channel carries one control tick item per cycle at most (valid/ready);
//   action=1 restarts the sequence and clears the actuator zero.
//   m_ channel returns exactly one result item per input item, in order.
//   cfg_wr_en/cfg_index/cfg_wdata write the stop velocity limit (index 0)
//   and the settle tick count (index 1); write only while the block is idle.
// path: an accepted item waits in the input register until the result register
//   is empty or being taken, is evaluated by the phase logic and lands in the
//   result register, where m_valid rises with it.
// throughput: one item per cycle while m_ready stays high; the phase state
//   update is one pass of compares and adds between input and result registers.
// reset: aresetn low (synchronous) empties both registers, puts the phase
//   to init, clears all counters, the zero offset and the calibrated flag,
//   and loads the register defaults (1000000 nm/s, 600 ticks).
// stall: when m_ready is low the result holds; one more item is taken into
//   the input register, then s_ready drops until the result is taken.
`default_nettype none
module gripper_homing_calibration_sequencer
    import ghcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire ghcs_in_t    s_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output ghcs_out_t        m_item,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_wdata
);

    // configuration registers
    logic [30:0] stop_vel_reg;
    logic [15:0] settle_reg;

    // pipeline registers
    logic      in_valid_reg;
    ghcs_in_t  in_item_reg;
    logic      out_valid_reg;
    ghcs_out_t out_item_reg;
    logic      advance;

    // sequencer state
    logic [2:0]         phase_reg, phase_next;
    logic [15:0]        stop_cnt_reg, stop_cnt_next;
    logic [1:0]         close_cnt_reg, close_cnt_next;
    logic signed [31:0] zero_off_reg, zero_off_next;
    logic [39:0]        odo_mark_reg, odo_mark_next;
    logic               cal_reg, cal_next;
    logic               hold_reg, hold_next;
    ghcs_out_t          res;

    // output stage moves when empty or taken; input stage then drains into it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_vel_reg <= STOP_VEL_RESET;
            settle_reg   <= SETTLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STOP_VEL: stop_vel_reg <= cfg_wdata;
                CFG_SETTLE:   settle_reg   <= cfg_wdata[15:0];
                default:      stop_vel_reg <= stop_vel_reg;
            endcase
        end
    end

    // single pass of the phase logic on the item in the input register
    always_comb begin
        logic [31:0]        mag;
        logic               settled;
        logic               not_moved;
        logic signed [33:0] cmd_wide;
        logic               cvalid;
        logic               drive;
        logic               zwrite;
        logic signed [31:0] azero;
        logic [1:0]         flt;
        logic signed [31:0] pos;

        pos            = in_item_reg.joint_position;
        phase_next     = phase_reg;
        stop_cnt_next  = stop_cnt_reg;
        close_cnt_next = close_cnt_reg;
        zero_off_next  = zero_off_reg;
        odo_mark_next  = odo_mark_reg;
        cal_next       = cal_reg;
        hold_next      = hold_reg;
        cvalid         = 1'b0;
        drive          = 1'b0;
        zwrite         = 1'b0;
        azero          = '0;
        flt            = FLT_NONE;
        cmd_wide       = '0;

        // exact speed magnitude, -2^31 gives 2^31 which is never below the limit
        mag = in_item_reg.joint_velocity[31]
            ? (32'd0 - 32'(in_item_reg.joint_velocity))
            : 32'(in_item_reg.joint_velocity);
        not_moved = ({1'b0, in_item_reg.odometer} < ({1'b0, odo_mark_reg} + ODO_MIN_MOVE));

        if (in_item_reg.action) begin
            phase_next = PH_INIT;
            cal_next   = 1'b0;
            zwrite     = 1'b1;
            settled    = 1'b0;
        end else begin
            drive = (phase_reg != PH_CAL) && (phase_reg != PH_SPARE);
            if (!cal_reg && (mag < {1'b0, stop_vel_reg})) begin
                if (stop_cnt_reg != 16'hFFFF) begin
                    stop_cnt_next = stop_cnt_reg + 16'd1;
                end
            end else begin
                stop_cnt_next = '0;
            end
            settled = (stop_cnt_next > settle_reg);

            unique case (phase_reg)
                PH_INIT: begin
                    phase_next = PH_START;
                end
                PH_START: begin
                    close_cnt_next = '0;
                    stop_cnt_next  = '0;
                    zwrite         = 1'b1;
                    cal_next       = 1'b0;
                    zero_off_next  = pos;
                    odo_mark_next  = in_item_reg.odometer;
                    cvalid         = 1'b1;
                    cmd_wide       = 34'(G_MT_BOTTOM) + 34'(pos);
                    phase_next     = PH_CLOSE;
                end
                PH_CLOSE: begin
                    if (settled) begin
                        stop_cnt_next = '0;
                        cvalid        = 1'b1;
                        if (close_cnt_reg != 2'd3) begin
                            close_cnt_next = close_cnt_reg + 2'd1;
                        end
                        if (close_cnt_next < CLOSE_PASSES) begin
                            zero_off_next = pos;
                            cmd_wide      = 34'(G_BO_BOTTOM) + 34'(pos);
                            phase_next    = PH_BACKOFF;
                        end else begin
                            // second bottom reached: latch the actuator zero
                            zwrite        = 1'b1;
                            azero         = in_item_reg.actuator_position;
                            zero_off_next = '0;
                            cmd_wide      = 34'(G_MT_TOP);
                            phase_next    = PH_TOP;
                        end
                    end
                end
                PH_BACKOFF: begin
                    if (settled) begin
                        if (not_moved) begin
                            flt = FLT_NOT_MOVED;
                        end
                        stop_cnt_next = '0;
                        cvalid        = 1'b1;
                        cmd_wide      = 34'(G_MT_CLOSED) + 34'(zero_off_reg);
                        phase_next    = PH_CLOSE;
                    end
                end
                PH_TOP: begin
                    if (settled) begin
                        stop_cnt_next = '0;
                        cvalid        = 1'b1;
                        if (pos < G_WRONG) begin
                            flt      = FLT_WRONG;
                            cmd_wide = 34'(G_BO_BOTTOM) + 34'(zero_off_reg);
                        end else if (pos > G_EMPTY) begin
                            flt      = FLT_MISSING;
                            cmd_wide = 34'(pos) - 34'(G_BO_INSTALL) + 34'(zero_off_reg);
                        end else begin
                            cmd_wide = 34'(G_OPEN) + 34'(zero_off_reg);
                        end
                        odo_mark_next = in_item_reg.odometer;
                        phase_next    = PH_HOME;
                    end
                end
                PH_HOME: begin
                    if (settled) begin
                        if (not_moved) begin
                            flt = FLT_NOT_MOVED;
                        end
                        stop_cnt_next = '0;
                        cal_next      = 1'b1;
                        hold_next     = 1'b0;
                        phase_next    = PH_CAL;
                    end
                end
                default: begin
                    // calibrated (and the unused code): one hold command
                    if (!hold_reg) begin
                        hold_next = 1'b1;
                        cvalid    = 1'b1;
                        cmd_wide  = 34'(pos);
                        drive     = 1'b1;
                    end
                end
            endcase
        end

        res.command_valid    = cvalid;
        res.command_position = cvalid ? sat32(cmd_wide) : 32'sd0;
        res.drive_enable     = drive;
        res.zero_write       = zwrite;
        res.actuator_zero    = azero;
        res.calibrated       = cal_next;
        res.fault            = flt;
        res.phase            = phase_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_INIT;
            stop_cnt_reg  <= '0;
            close_cnt_reg <= '0;
            zero_off_reg  <= '0;
            odo_mark_reg  <= '0;
            cal_reg       <= 1'b0;
            hold_reg      <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                stop_cnt_reg  <= stop_cnt_next;
                close_cnt_reg <= close_cnt_next;
                zero_off_reg  <= zero_off_next;
                odo_mark_reg  <= odo_mark_next;
                cal_reg       <= cal_next;
                hold_reg      <= hold_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= res;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/ghcs_checker.sv
// port level checks for the gripper homing calibration sequencer
`default_nettype none
module ghcs_checker
    import ghcs_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire ghcs_out_t m_item
);

    // a stalled result keeps its contents
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // no command means a zero command position
    a_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.command_valid |-> m_item.command_position == 32'sd0)
        else $error("command position without command");

    // no zero write means a zero actuator value
    a_zero_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.zero_write |-> m_item.actuator_zero == 32'sd0)
        else $error("actuator zero without write");

    // the calibrated flag only stands in the calibrated phase
    a_cal_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.calibrated |-> m_item.phase == PH_CAL)
        else $error("calibrated outside calibrated phase");

    // install faults come with the move toward home
    a_install_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.fault == FLT_WRONG || m_item.fault == FLT_MISSING)
        |-> m_item.phase == PH_HOME && m_item.command_valid)
        else $error("install fault outside top classification");

endmodule

bind gripper_homing_calibration_sequencer ghcs_checker u_ghcs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire

FILE: test/ghcs_sequence_checker.sv
// checker for the homing sequencer: predicts every result item and compares it on the m_ channel
module ghcs_sequence_checker
    import ghcs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire ghcs_in_t    s_item,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire ghcs_out_t   m_item,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [30:0] cfg_wdata,
    output int               mismatches,
    output int               pending
);

    // goal positions in nm
    localparam longint GOAL_TOP      = 64'sd16500000;
    localparam longint GOAL_EMPTY    = 64'sd15000000;
    localparam longint GOAL_OPEN     = 64'sd11300000;
    localparam longint GOAL_INSTALL  = 64'sd700000;
    localparam longint GOAL_WRONG    = 64'sd9000000;
    localparam longint GOAL_BACKOFF  = 64'sd3000000;
    localparam longint GOAL_CLOSED   = -64'sd4000000;
    localparam longint GOAL_BOTTOM   = -64'sd17000000;
    localparam longint MIN_TRAVEL    = 64'sd1000000;
    localparam longint S32_MAX       = 64'sd2147483647;
    localparam longint S32_MIN       = -64'sd2147483648;
    localparam logic [1:0]  CLOSES_NEEDED = 2'd2;
    localparam logic [1:0]  CLOSE_CNT_MAX = 2'd3;
    localparam logic [15:0] STOP_CNT_MAX  = 16'hFFFF;

    logic [30:0] vel_limit;
    logic [15:0] settle_len;

    logic [2:0]  phase_q;
    logic [15:0] stop_cnt;
    logic [1:0]  close_cnt;
    longint      zero_off;
    longint      odo_mark;
    logic        cal_q;
    logic        hold_done;

    ghcs_out_t   tick_results_q[$];
    int          result_no;

    function automatic ghcs_out_t advance_homing(input ghcs_in_t it);
        ghcs_out_t res;
        longint pos, vel, mag, odo, cmd, azero;
        logic cmd_on, drive_on, zero_on, settled;
        logic [1:0] flt;
        pos = longint'($signed(it.joint_position));
        vel = longint'($signed(it.joint_velocity));
        odo = longint'(it.odometer);
        cmd = 0;
        azero = 0;
        cmd_on = 1'b0;
        drive_on = 1'b0;
        zero_on = 1'b0;
        flt = FLT_NONE;
        if (it.action) begin
            phase_q = PH_INIT;
            cal_q = 1'b0;
            zero_on = 1'b1;
        end else begin
            drive_on = (phase_q < PH_CAL);
            mag = (vel < 0) ? -vel : vel;
            if (!cal_q && mag < longint'(vel_limit)) begin
                if (stop_cnt != STOP_CNT_MAX) stop_cnt = stop_cnt + 1'b1;
            end else begin
                stop_cnt = '0;
            end
            settled = (stop_cnt > settle_len);
            case (phase_q)
                PH_INIT: begin
                    phase_q = PH_START;
                end
                PH_START: begin
                    close_cnt = '0;
                    stop_cnt = '0;
                    zero_on = 1'b1;
                    cal_q = 1'b0;
                    zero_off = pos;
                    odo_mark = odo;
                    cmd_on = 1'b1;
                    cmd = GOAL_BOTTOM + zero_off;
                    phase_q = PH_CLOSE;
                end
                PH_CLOSE: begin
                    if (settled) begin
                        stop_cnt = '0;
                        zero_off = pos;
                        if (close_cnt != CLOSE_CNT_MAX) close_cnt = close_cnt + 1'b1;
                        cmd_on = 1'b1;
                        if (close_cnt < CLOSES_NEEDED) begin
                            cmd = GOAL_BACKOFF + zero_off;
                            phase_q = PH_BACKOFF;
                        end else begin
                            zero_on = 1'b1;
                            azero = longint'($signed(it.actuator_position));
                            zero_off = 0;
                            cmd = GOAL_TOP + zero_off;
                            phase_q = PH_TOP;
                        end
                    end
                end
                PH_BACKOFF: begin
                    if (settled) begin
                        if (odo < odo_mark + MIN_TRAVEL) flt = FLT_NOT_MOVED;
                        stop_cnt = '0;
                        cmd_on = 1'b1;
                        cmd = GOAL_CLOSED + zero_off;
                        phase_q = PH_CLOSE;
                    end
                end
                PH_TOP: begin
                    if (settled) begin
                        stop_cnt = '0;
                        cmd_on = 1'b1;
                        if (pos < GOAL_WRONG) begin
                            flt = FLT_WRONG;
                            cmd = GOAL_BACKOFF + zero_off;
                        end else if (pos > GOAL_EMPTY) begin
                            flt = FLT_MISSING;
                            cmd = pos - GOAL_INSTALL + zero_off;
                        end else begin
                            cmd = GOAL_OPEN + zero_off;
                        end
                        odo_mark = odo;
                        phase_q = PH_HOME;
                    end
                end
                PH_HOME: begin
                    if (settled) begin
                        if (odo < odo_mark + MIN_TRAVEL) flt = FLT_NOT_MOVED;
                        stop_cnt = '0;
                        cal_q = 1'b1;
                        hold_done = 1'b0;
                        phase_q = PH_CAL;
                    end
                end
                default: begin
                    // calibrated, and any unused code: one hold command only
                    if (!hold_done) begin
                        hold_done = 1'b1;
                        cmd_on = 1'b1;
                        cmd = pos;
                        drive_on = 1'b1;
                    end
                end
            endcase
        end
        if (cmd > S32_MAX) begin
            cmd = S32_MAX;
        end else if (cmd < S32_MIN) begin
            cmd = S32_MIN;
        end
        res.command_valid    = cmd_on;
        res.command_position = cmd_on ? cmd[31:0] : '0;
        res.drive_enable     = drive_on;
        res.zero_write       = zero_on;
        res.actuator_zero    = zero_on ? azero[31:0] : '0;
        res.calibrated       = cal_q;
        res.fault            = flt;
        res.phase            = phase_q;
        return res;
    endfunction

    always @(posedge aclk) begin : track
        ghcs_out_t want;
        if (!aresetn) begin
            vel_limit = 31'd1000000;
            settle_len = 16'd600;
            phase_q = PH_INIT;
            stop_cnt = '0;
            close_cnt = '0;
            zero_off = 0;
            odo_mark = 0;
            cal_q = 1'b0;
            hold_done = 1'b0;
            result_no = 0;
            tick_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (tick_results_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no item outstanding", result_no);
                end else begin
                    want = tick_results_q.pop_front();
                    if (m_item !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch", result_no);
                            if (m_item.command_valid !== want.command_valid)
                                $display("  command_valid exp %0d got %0d",
                                         want.command_valid, m_item.command_valid);
                            if (m_item.command_position !== want.command_position)
                                $display("  command_position exp %0d got %0d",
                                         want.command_position, m_item.command_position);
                            if (m_item.drive_enable !== want.drive_enable)
                                $display("  drive_enable exp %0d got %0d",
                                         want.drive_enable, m_item.drive_enable);
                            if (m_item.zero_write !== want.zero_write)
                                $display("  zero_write exp %0d got %0d",
                                         want.zero_write, m_item.zero_write);
                            if (m_item.actuator_zero !== want.actuator_zero)
                                $display("  actuator_zero exp %0d got %0d",
                                         want.actuator_zero, m_item.actuator_zero);
                            if (m_item.calibrated !== want.calibrated)
                                $display("  calibrated exp %0d got %0d",
                                         want.calibrated, m_item.calibrated);
                            if (m_item.fault !== want.fault)
                                $display("  fault exp %0d got %0d", want.fault, m_item.fault);
                            if (m_item.phase !== want.phase)
                                $display("  phase exp %0d got %0d", want.phase, m_item.phase);
                        end
                    end
                end
                result_no++;
            end
            if (s_valid && s_ready)
                tick_results_q.insert(tick_results_q.size(), advance_homing(s_item));
            if (cfg_wr_en) begin
                if (cfg_index == CFG_STOP_VEL) begin
                    vel_limit = cfg_wdata;
                end else begin
                    settle_len = cfg_wdata[15:0];
                end
            end
        end
        pending = tick_results_q.size();
    end

endmodule

FILE: test/tb_top.sv
// testbench top for the homing sequencer: clock, reset, stimulus and verdict
module tb_top;
    import ghcs_pkg::*;

    localparam logic signed [31:0] S_MIN = 32'sh80000000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
    localparam logic [39:0] ODO_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;
    // long receiver hold-off, well below the watchdog limit
    localparam int HOLD_OFF_CYCLES = 300;
    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ghcs_in_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ghcs_out_t   m_item;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = CFG_STOP_VEL;
    logic [30:0] cfg_wdata = '0;

    int          mismatches;
    int          pending;

    // stimulus-side copy of the settings, used to shape velocities
    logic [30:0] vel_limit = 31'd1000000;
    logic [15:0] settle_len = 16'd600;
    // running odometer so most items show plausible travel
    logic [39:0] odo_run = '0;
    bit          idling = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned quiet_cycles = 0;

    always #6 aclk = ~aclk;

    gripper_homing_calibration_sequencer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ghcs_sequence_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // hang detection: any accepted item on either side restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: short random stalls, or one long hold-off on request
    initial begin
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // offer one item, maybe after a short gap, and return on the edge that takes it
    task automatic push_item(input ghcs_in_t it);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // settings change only once every result is back and the pipeline has drained
    task automatic write_settings(input logic [30:0] limit, input logic [15:0] settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_STOP_VEL;
        cfg_wdata <= limit;
        @(posedge aclk);
        cfg_index <= CFG_SETTLE;
        cfg_wdata <= {15'd0, settle};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        vel_limit = limit;
        settle_len = settle;
    endtask

    function automatic ghcs_in_t tick_item(input logic act, input logic signed [31:0] pos,
                                           input logic signed [31:0] vel,
                                           input logic [39:0] odo,
                                           input logic signed [31:0] apos);
        ghcs_in_t it;
        it.action = act;
        it.joint_position = pos;
        it.joint_velocity = vel;
        it.odometer = odo;
        it.actuator_position = apos;
        return it;
    endfunction

    // often the classification band, some corner values, the rest anywhere
    function automatic logic signed [31:0] pick_position();
        int unsigned r;
        logic signed [31:0] p;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            p = $urandom_range(8000000, 16000000);
        end else if (r < 55) begin
            case ($urandom_range(0, 7))
                0: p = S_MIN;
                1: p = S_MAX;
                2: p = 0;
                3: p = -1;
                4: p = 32'sd9000000;
                5: p = 32'sd8999999;
                6: p = 32'sd15000000;
                default: p = 32'sd15000001;
            endcase
        end else begin
            p = $urandom;
        end
        return p;
    endfunction

    // calm: always below the stop limit when the limit allows it
    function automatic logic signed [31:0] pick_velocity(input bit calm);
        int unsigned r;
        logic signed [31:0] v;
        r = $urandom_range(0, 99);
        if (vel_limit != 0 && (calm || r < 80)) begin
            if ($urandom_range(0, 19) == 0) begin
                v = $signed({1'b0, vel_limit - 1'b1});
            end else begin
                v = $urandom_range(0, vel_limit - 1);
            end
            if ($urandom_range(0, 1)) v = -v;
        end else if (r < 90) begin
            v = $urandom;
        end else begin
            case ($urandom_range(0, 4))
                0: v = S_MIN;
                1: v = S_MAX;
                2: v = $signed({1'b0, vel_limit});
                3: v = -$signed({1'b0, vel_limit});
                default: v = 0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [39:0] pick_odometer();
        int unsigned r;
        logic [63:0] w;
        logic [39:0] o;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            odo_run = odo_run + $urandom_range(0, 700000);
            o = odo_run;
        end else if (r < 80) begin
            o = odo_run;
        end else if (r < 92) begin
            w = {$urandom, $urandom};
            o = w[39:0];
        end else begin
            o = $urandom_range(0, 1) ? ODO_MAX : '0;
        end
        return o;
    endfunction

    function automatic logic signed [31:0] pick_actuator();
        logic signed [31:0] a;
        case ($urandom_range(0, 9))
            0: a = S_MIN;
            1: a = S_MAX;
            2: a = -1;
            default: a = $urandom;
        endcase
        return a;
    endfunction

    // noisy items come with frequent restarts and unbounded velocities
    function automatic ghcs_in_t make_tick(input bit calm, input bit noisy);
        ghcs_in_t it;
        if (calm) begin
            it.action = 1'b0;
        end else if (noisy) begin
            it.action = ($urandom_range(0, 3) == 0);
        end else begin
            it.action = ($urandom_range(0, 49) == 0);
        end
        it.joint_position = pick_position();
        it.joint_velocity = noisy ? $signed($urandom) : pick_velocity(calm);
        it.odometer = pick_odometer();
        it.actuator_position = pick_actuator();
        return it;
    endfunction

    function automatic ghcs_in_t restart_item();
        return tick_item(1'b1, pick_position(), $signed($urandom), pick_odometer(),
                         pick_actuator());
    endfunction

    // restart followed by a run of ticks of random length, often long enough to walk through the phases
    task automatic run_sequences(input int n);
        int sent;
        int len;
        bit noisy;
        sent = 0;
        while (sent < n) begin
            noisy = ($urandom_range(0, 9) == 0);
            push_item(restart_item());
            sent++;
            len = $urandom_range(6, 10 * (int'(settle_len) + 2));
            repeat (len) begin
                push_item(make_tick(1'b0, noisy));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idling = 1'b1;

        // reset settings: 600 settle ticks under the 1 mm/s limit must close the first pass
        push_item(restart_item());
        repeat (650) push_item(make_tick(1'b1, 1'b0));

        // directed walk with the widest limit and the shortest settle
        write_settings(LIMIT_MAX, 16'd1);
        push_item(tick_item(1'b1, S_MAX, S_MIN, ODO_MAX, S_MAX));
        push_item(tick_item(1'b0, 0, 0, 0, 0));
        // start: bottom goal below the signed range
        push_item(tick_item(1'b0, S_MIN, 0, 40'd0, 0));
        // full-scale speeds never count as stopped
        push_item(tick_item(1'b0, 0, S_MIN, 40'd10, 0));
        push_item(tick_item(1'b0, 0, S_MAX, 40'd20, 0));
        push_item(tick_item(1'b0, 0, 32'sd2147483646, 40'd30, 0));
        // first close ends, back-off goal above the signed range
        push_item(tick_item(1'b0, S_MAX, -32'sd2147483646, 40'd40, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd50, 0));
        // back-off ends with too little travel
        push_item(tick_item(1'b0, 0, 0, 40'd999999, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd1000000, 0));
        // second close latches the actuator zero
        push_item(tick_item(1'b0, -5, 0, 40'd2000000, S_MIN));
        push_item(tick_item(1'b0, 0, 0, 40'd3000000, 0));
        // top end past the empty mark: gripper missing
        push_item(tick_item(1'b0, 32'sd15000001, 0, 40'd5000000, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd5500000, 0));
        // home with travel exactly at the minimum
        push_item(tick_item(1'b0, 0, 0, 40'd6000000, 0));
        // single hold command, then nothing
        push_item(tick_item(1'b0, 32'sd1234, 0, 40'd6000000, 0));
        push_item(tick_item(1'b0, 32'sd4321, 0, 40'd6000000, 0));
        push_item(tick_item(1'b1, 0, 0, 0, -1));
        push_item(tick_item(1'b0, 0, 0, 0, 0));
        // mark at the top of the odometer range
        push_item(tick_item(1'b0, 0, 0, ODO_MAX, 0));
        push_item(tick_item(1'b0, 0, 0, ODO_MAX, 0));
        push_item(tick_item(1'b0, 32'sd2000000, 0, ODO_MAX, 0));
        push_item(tick_item(1'b0, 0, 0, ODO_MAX, 0));
        push_item(tick_item(1'b0, 0, 0, ODO_MAX, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd0, 0));
        push_item(tick_item(1'b0, 32'sd100, 0, 40'd0, 32'sd77));
        push_item(tick_item(1'b0, 0, 0, 40'd0, 0));
        // top end short of the wrong-install mark
        push_item(tick_item(1'b0, 32'sd8999999, 0, 40'd500, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd500, 0));
        push_item(tick_item(1'b0, 0, 0, 40'd999999, 0));

        // random sequences across several settings
        write_settings(31'd1000, 16'd1);
        run_sequences(100);
        write_settings(31'($urandom_range(1, 5000000)), 16'($urandom_range(1, 4)));
        // receiver holds off while the sender keeps offering
        hold_off_req = 1'b1;
        run_sequences(100);
        write_settings(31'd0, 16'd1);
        run_sequences(30);
        write_settings(LIMIT_MAX, 16'd2);
        run_sequences(100);
        write_settings(31'd1000000, 16'd3);
        run_sequences(100);

        // last part runs at full rate on both sides
        idling = 1'b0;
        write_settings(31'($urandom_range(1, 3000000)), 16'd1);
        run_sequences(140);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
